// File: hdl/ssfp_pkg.sv
// Shared types and constants for the servo status frame parser.
package ssfp_pkg;

    localparam int          SLOT_COUNT      = 6;
    localparam int          FRAME_DEPTH     = 8;
    localparam int          SLOT_W          = 3;
    localparam int          COUNT_W         = 9;
    localparam int          POS_W           = 16;
    localparam int          M_TDATA_W       = 24;
    localparam logic [7:0]  HEADER_BYTE     = 8'hFF;
    localparam logic [8:0]  FRAME_LEN       = 9'd8;
    localparam logic [8:0]  HUNT_WINDOW     = 9'd4;
    localparam logic [8:0]  LEN_OVERHEAD    = 9'd4;
    localparam logic [SLOT_W-1:0] CLAW_FIRST_SLOT = 3'd4;

    typedef enum logic [1:0] {
        STATUS_KNOWN        = 2'd0,
        STATUS_UNKNOWN_ID   = 2'd1,
        STATUS_BAD_LENGTH   = 2'd2,
        STATUS_BAD_CHECKSUM = 2'd3
    } status_t;

    typedef struct packed {
        logic              valid;
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  position;
    } result_t;

endpackage

// File: hdl/servo_status_frame_parser_top.sv
// Servo status frame parser: one received bus byte in per beat, one status beat per closed frame.
// Accepts one byte per clock cycle without pause while m_tready keeps up; m_tvalid rises when the
// beat that closes its frame moves from the input register into the output register. The rate is
// set by the single parser stage, which stores the byte, slides the header window, counts the
// frame and checks length, checksum and id between the two registers. While a status beat
// waits with m_tready low, the parser holds the next byte whether or not it closes a frame, and
// intake stops once the input register is full as well. Id registers may be written at any time
// the parser holds no unfinished byte; indices 6 and 7 are ignored.
module servo_status_frame_parser_top import ssfp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [1:0] frame_status, [4:2] servo_slot,
                                            // [20:5] servo_position, [23:21] zero
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [SLOT_W-1:0]    cfg_index,
    input  logic [7:0]           cfg_data
);

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       proc_fire;
    result_t    result;

    assign cfg_ready = 1'b1;
    assign proc_fire = byte_valid && (!m_tvalid || m_tready);

    ssfp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (proc_fire),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    ssfp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (proc_fire),
        .rx_byte   (byte_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

    ssfp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (proc_fire),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_idle_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != STATUS_KNOWN) |-> (m_tdata[20:2] == '0))
        else $error("non-update status carries slot or position");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (int'(m_tdata[4:2]) < SLOT_COUNT))
        else $error("slot out of range");

    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (byte_valid && m_tvalid && !m_tready))
        else $error("intake stalled without a blocked result");

endmodule

// File: hdl/ssfp_in_stage.sv
// Input register for received bytes.
module ssfp_in_stage import ssfp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       take,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic [7:0] data_reg;

    assign s_tready   = !valid_reg || take;
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
        end
    end

endmodule

// File: hdl/ssfp_parser.sv
// Frame store, byte counter, id registers and single-pass frame check.
module ssfp_parser import ssfp_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    fire,
    input  logic [7:0]              rx_byte,
    input  logic                    cfg_we,
    input  logic [SLOT_W-1:0]       cfg_index,
    input  logic [7:0]              cfg_data,
    output result_t                 result
);

    logic [7:0]         frame_reg [FRAME_DEPTH];
    logic [7:0]         frame_next [FRAME_DEPTH];
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] need;
    logic [7:0]         sum;
    logic [7:0]         id_reg [SLOT_COUNT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
                id_reg[k] <= 8'(k + 1);
            end
        end else if (cfg_we && (int'(cfg_index) < SLOT_COUNT)) begin
            id_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
    end

    always_comb begin
        frame_next = frame_reg;
        count_next = count_reg;
        count_inc  = count_reg + 9'd1;
        need       = '0;
        sum        = '0;
        result     = '0;
        if (fire) begin
            if (count_reg < FRAME_LEN) begin
                frame_next[count_reg[2:0]] = rx_byte;
            end
            priority if (count_inc < HUNT_WINDOW) begin
                count_next = count_inc;
            end else if (frame_next[0] != HEADER_BYTE || frame_next[1] != HEADER_BYTE) begin
                // drop the oldest byte
                frame_next[0] = frame_next[1];
                frame_next[1] = frame_next[2];
                frame_next[2] = frame_next[3];
                count_next    = count_inc - 9'd1;
            end else begin
                need = {1'b0, frame_next[3]} + LEN_OVERHEAD;
                if (count_inc < need) begin
                    count_next = count_inc;
                end else begin
                    count_next   = '0;
                    result.valid = 1'b1;
                    sum = frame_next[2] + frame_next[3] + frame_next[4]
                        + frame_next[5] + frame_next[6];
                    priority if (count_inc != FRAME_LEN) begin
                        result.status = STATUS_BAD_LENGTH;
                    end else if (frame_next[7] != ~sum) begin
                        result.status = STATUS_BAD_CHECKSUM;
                    end else begin
                        result.status = STATUS_UNKNOWN_ID;
                        // scan downwards so the lowest matching slot wins
                        for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
                            if (id_reg[k] == frame_next[2]) begin
                                result.status = STATUS_KNOWN;
                                result.slot   = SLOT_W'(k);
                                if (SLOT_W'(k) >= CLAW_FIRST_SLOT) begin
                                    result.position = {frame_next[5], frame_next[6]};
                                end else begin
                                    result.position = {frame_next[6], frame_next[5]};
                                end
                            end
                        end
                    end
                end
            end
        end
    end

endmodule

// File: hdl/ssfp_out_stage.sv
// Output register for status beats.
module ssfp_out_stage import ssfp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  result_t              result,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic    valid_reg;
    result_t data_reg;

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, data_reg.position, data_reg.slot, data_reg.status};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= result.valid;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && result.valid) begin
            data_reg <= result;
        end
    end

endmodule

// File: verif/servo_status_frame_parser_top_tb.sv
// Self-checking testbench for the servo status frame parser: directed frames, then random byte runs.
`timescale 1ns / 100ps

module servo_status_frame_parser_top_tb;
    import ssfp_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BYTES = 250;
    localparam int PHASES      = 5;

    localparam logic [SLOT_W-1:0] REG_BASE_ID       = 3'd0;
    localparam logic [SLOT_W-1:0] REG_CLAW_RIGHT_ID = 3'd5;
    localparam logic [SLOT_W-1:0] REG_UNUSED        = 3'd7;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  position;
    } status_beat_t;

    typedef struct packed {
        logic [7:0]        rx;
        logic              fixed;
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  position;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [SLOT_W-1:0]    cfg_index;
    logic [7:0]           cfg_data;

    // parser mirror
    logic [7:0]         frame_store [FRAME_DEPTH];
    logic [COUNT_W-1:0] frame_count;
    logic [7:0]         slot_ids [SLOT_COUNT];

    status_beat_t status_due [$];
    status_beat_t want;

    int  mismatches;
    int  burst_left;
    int  bytes_in;
    int  framed_bytes;
    int  id_writes;
    int  status_seen [4];
    int  quiet_cycles;
    bit  hold_req;
    bit  hold_taken;
    int  hold_left;
    int  rx_mode;
    int  mode_left;

    // short frame, claw frame, checksum error, long frame
    dir_row_t dir_rows [29] = '{
        '{8'hFF, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'hFF, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'h07, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'h00, 1'b1, STATUS_BAD_LENGTH, 3'd0, 16'h0000},
        '{8'hFF, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'hFF, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'h05, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'h04, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'h00, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'h34, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'h12, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'hB0, 1'b1, STATUS_KNOWN, 3'd4, 16'h3412},
        '{8'hFF, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'hFF, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'h01, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'h04, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'h00, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'hFF, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'hFF, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'h00, 1'b1, STATUS_BAD_CHECKSUM, 3'd0, 16'h0000},
        '{8'hFF, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'hFF, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'h02, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'h05, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'h00, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'h00, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'h00, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'h00, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000},
        '{8'h00, 1'b0, STATUS_KNOWN, 3'd0, 16'h0000}
    };

    servo_status_frame_parser_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic bit parse_rx_byte(input logic [7:0] b, output status_beat_t beat);
        logic [COUNT_W-1:0] need;
        logic [7:0]         sum;
        beat = '0;
        if (frame_count < FRAME_LEN) frame_store[frame_count[2:0]] = b;
        frame_count = frame_count + 1'b1;
        if (frame_count < HUNT_WINDOW) return 1'b0;
        if (frame_store[0] != HEADER_BYTE || frame_store[1] != HEADER_BYTE) begin
            frame_store[0] = frame_store[1];
            frame_store[1] = frame_store[2];
            frame_store[2] = frame_store[3];
            frame_count = frame_count - 1'b1;
            return 1'b0;
        end
        need = {1'b0, frame_store[3]} + LEN_OVERHEAD;
        if (frame_count < need) return 1'b0;
        sum = frame_store[2] + frame_store[3] + frame_store[4] + frame_store[5] + frame_store[6];
        if (frame_count != FRAME_LEN) begin
            beat.status = STATUS_BAD_LENGTH;
        end else if (frame_store[7] != ~sum) begin
            beat.status = STATUS_BAD_CHECKSUM;
        end else begin
            beat.status = STATUS_UNKNOWN_ID;
            // scan downwards so that the lowest matching slot wins
            for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
                if (slot_ids[k] == frame_store[2]) begin
                    beat.status   = STATUS_KNOWN;
                    beat.slot     = SLOT_W'(k);
                    beat.position = (k >= CLAW_FIRST_SLOT) ? {frame_store[5], frame_store[6]}
                                                           : {frame_store[6], frame_store[5]};
                end
            end
        end
        frame_count = '0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endfunction

    task automatic push_byte(input logic [7:0] b, input bit fixed, input status_beat_t typed);
        status_beat_t beat;
        bit           closed;
        int           gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                s_tdata  = 8'($urandom);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        bytes_in++;
        closed = parse_rx_byte(b, beat);
        if (fixed) status_due.push_back(typed);
        else if (closed) status_due.push_back(beat);
    endtask

    task automatic drain_status();
        @(negedge aclk);
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (status_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_id(input logic [SLOT_W-1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx <= REG_CLAW_RIGHT_ID) slot_ids[idx] = val;
        id_writes++;
    endtask

    task automatic send_random_run(output int framed);
        logic [7:0] fr [$];
        logic [7:0] len;
        logic [7:0] cks;
        int         kind;
        kind = $urandom_range(0, 99);
        framed = 0;
        if (kind >= 88) begin
            repeat ($urandom_range(1, 4)) push_byte(pick_byte(), 1'b0, '0);
            return;
        end
        fr.push_back(HEADER_BYTE);
        fr.push_back(HEADER_BYTE);
        fr.push_back(kind < 45 ? slot_ids[$urandom_range(0, SLOT_COUNT - 1)] : pick_byte());
        if (kind < 70)      len = 8'd4;
        else if (kind < 80) len = 8'($urandom_range(0, 3));
        else if ($urandom_range(0, 9) == 0) len = 8'($urandom_range(13, 255));
        else                len = 8'($urandom_range(5, 12));
        fr.push_back(len);
        if (len == 8'd4) begin
            repeat (3) fr.push_back(pick_byte());
            cks = ~(fr[2] + fr[3] + fr[4] + fr[5] + fr[6]);
            if (kind >= 55) cks = cks ^ 8'($urandom_range(1, 255));
            fr.push_back(cks);
        end else begin
            repeat (len) fr.push_back(pick_byte());
        end
        foreach (fr[i]) push_byte(fr[i], 1'b0, '0);
        framed = fr.size();
    endtask

    // receiver: own stall pattern, plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            case (rx_mode)
                0: m_tready = 1'b1;
                1: m_tready = 1'($urandom_range(0, 1));
                default: m_tready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d status beats outstanding",
                     quiet_cycles, status_due.size());
            $display("TB_ERROR");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            status_seen[m_tdata[1:0]]++;
            if (status_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected status beat: m_tdata=%h", m_tdata));
            end else begin
                want = status_due.pop_front();
                if (m_tdata[1:0] != want.status || m_tdata[4:2] != want.slot ||
                    m_tdata[20:5] != want.position || m_tdata[23:21] != 3'd0)
                    flag_mismatch($sformatf(
                        "status beat mismatch: expected status=%0d slot=%0d pos=%h, got %0d %0d %h pad=%0d",
                        want.status, want.slot, want.position,
                        m_tdata[1:0], m_tdata[4:2], m_tdata[20:5], m_tdata[23:21]));
            end
        end
    end

    initial begin
        logic [7:0] next_ids [SLOT_COUNT];
        logic [7:0] dup_id;
        int         phase_bytes;
        int         framed;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        cfg_valid = 1'b0;
        cfg_index = REG_BASE_ID;
        cfg_data  = 8'h00;
        frame_count = '0;
        foreach (frame_store[i]) frame_store[i] = 8'h00;
        foreach (slot_ids[i]) slot_ids[i] = 8'(i + 1);
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[i])
            push_byte(dir_rows[i].rx, dir_rows[i].fixed,
                      '{dir_rows[i].status, dir_rows[i].slot, dir_rows[i].position});

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                drain_status();
                case (phase)
                    1: next_ids = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F};
                    2: foreach (next_ids[i]) next_ids[i] = 8'($urandom);
                    3: begin
                        dup_id = 8'($urandom);
                        foreach (next_ids[i]) next_ids[i] = dup_id;
                    end
                    default: next_ids = '{8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'h01, 8'h00};
                endcase
                for (int r = REG_BASE_ID; r <= REG_CLAW_RIGHT_ID; r++)
                    write_id(SLOT_W'(r), next_ids[r]);
                if (phase == 2) begin
                    write_id(REG_UNUSED, 8'($urandom));
                    hold_req = 1'b1;
                end
                @(negedge aclk);
                cfg_valid = 1'b0;
            end
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                send_random_run(framed);
                phase_bytes += framed;
            end
            framed_bytes += phase_bytes;
        end

        drain_status();
        $display("covered %0d bytes (%0d in random frames), %0d id writes over %0d id settings",
                 bytes_in, framed_bytes, id_writes, PHASES);
        $display("status beats: known %0d, unknown id %0d, bad length %0d, bad checksum %0d",
                 status_seen[STATUS_KNOWN], status_seen[STATUS_UNKNOWN_ID],
                 status_seen[STATUS_BAD_LENGTH], status_seen[STATUS_BAD_CHECKSUM]);
        if (mismatches == 0 && status_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d status beats outstanding", mismatches,
                     status_due.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
